### hdl/vpd_pkg.sv
// Shared types, widths and helpers for the PD velocity step unit.
// No dependencies; used by every module in hdl/.
package vpd_pkg;

    localparam int STEP_SHIFT_DEF = 6;
    localparam int MUL_W = 34;
    localparam int DS_W = 64;
    localparam int DS_REM_W = 36;
    localparam int DEN_W = 33;

    typedef enum logic [1:0] {
        DS_DIV  = 2'b01,
        DS_SQRT = 2'b10
    } ds_mode_t;

    // saturate a wide signed value to 32 bits
    function automatic logic signed [31:0] sat32(input logic signed [69:0] v);
        logic ovf;
        ovf = !((&v[69:31]) || !(|v[69:31]));
        if (ovf) begin
            sat32 = v[69] ? 32'sh80000000 : 32'sh7fffffff;
        end else begin
            sat32 = v[31:0];
        end
    endfunction

endpackage

### hdl/vehicle_pd_velocity_step_unit.sv
// PD velocity step unit: top level with step sequencer and state.
// Depends on vpd_pkg, vpd_mul and vpd_divsqrt.
//
// Input stream (s_): one beat per step. tuser[0] is op (0 step, 1 load);
// tdata carries the target (or loaded) position x,y,z then velocity x,y,z.
// Output stream (m_): one beat per input beat with the new position,
// velocity and the two limit flags.
// Config channel: cfg_index selects a register, cfg_data is the value;
// always ready, write only while the unit is idle.
// A load skips the multiply steps and goes from idle to the finish state,
// which loads the result register once the output slot is free. A step runs
// one serial multiplier for 12 products; a limited horizontal command adds
// 2 products, one square root and two divides. m_tvalid and s_tready rise in
// the same cycle, so the next beat can be taken as soon as the result is valid.
// One beat is in flight at a time; s_tready is high only while idle.
// Reset clears position, velocity and all config registers to zero.
// A stalled receiver holds the result register; the next beat may be
// taken and computed but is not delivered until the result slot frees.
module vehicle_pd_velocity_step_unit #(
    parameter int STEP_SHIFT = vpd_pkg::STEP_SHIFT_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // aim_px, aim_py, aim_pz, aim_vx, aim_vy, aim_vz
    input  logic [191:0] s_tdata,
    // op
    input  logic [0:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, horiz_limited, vert_limited, pad
    output logic [199:0] m_tdata,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [2:0]   cfg_index,
    input  logic [31:0]  cfg_data
);
    import vpd_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_ISSUE = 4'b0010,
        ST_WAIT  = 4'b0100,
        ST_FIN   = 4'b1000
    } state_t;

    localparam logic [2:0] R_GPXZ = 3'd0, R_GVEL = 3'd1, R_GPY = 3'd2, R_MAXXZ = 3'd3,
                           R_MAXY = 3'd4, R_MINY = 3'd5, R_LAGXZ = 3'd6, R_LAGY = 3'd7;

    localparam logic [4:0] K_CY = 5'd3, K_CZ2 = 5'd7, K_LIM = 5'd8, K_SQRT = 5'd9,
                           K_DIVX = 5'd11, K_DIVZ = 5'd13, K_LAGX = 5'd14,
                           K_LAGZ = 5'd16;

    state_t state_reg;
    logic [4:0] step_reg, step_next;

    logic signed [31:0] gpxz_reg, gvel_reg, gpy_reg, maxy_reg, miny_reg;
    logic [30:0] maxxz_reg;
    logic [15:0] lagxz_reg, lagy_reg;

    logic signed [31:0] pos_reg [3];
    logic signed [31:0] vel_reg [3];
    logic signed [31:0] aimp_reg [3];
    logic signed [31:0] aimv_reg [3];
    logic signed [31:0] c_reg [3];
    logic signed [31:0] nv_reg [3];
    logic op_reg, hl_reg, vl_reg, neg_reg;
    logic signed [2*MUL_W-1:0] acc_reg;
    logic [DS_W-1:0] n2_reg;
    logic [DEN_W-1:0] n_reg;
    logic m_valid_reg;
    logic [199:0] m_data_reg;

    logic mul_start, mul_done, ds_start, ds_done;
    logic signed [MUL_W-1:0] mul_a, mul_b;
    logic signed [2*MUL_W-1:0] mul_p;
    ds_mode_t ds_mode;
    logic [DS_W-1:0] ds_num, ds_res, prod_mag;
    logic [1:0] ax;
    logic signed [31:0] ep_sel, ev_sel, cmd;
    logic signed [69:0] cmd_sum;
    logic out_free, s_acc;

    assign s_tready  = state_reg == ST_IDLE;
    assign s_acc     = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign out_free  = !m_valid_reg || m_tready;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = m_data_reg;

    always_comb begin
        case (step_reg)
            5'd0, 5'd1, 5'd6, 5'd10, 5'd11, K_LAGX: ax = 2'd0;
            5'd2, K_CY, 5'd15:                       ax = 2'd1;
            default:                                 ax = 2'd2;
        endcase
        ep_sel = sat32(70'(pos_reg[ax]) - 70'(aimp_reg[ax]));
        ev_sel = sat32(70'(vel_reg[ax]) - 70'(aimv_reg[ax]));
        // command sum wraps at 64 bits
        cmd_sum = 70'($signed(acc_reg[DS_W-1:0] + mul_p[DS_W-1:0]));
        cmd = sat32(cmd_sum >>> 16);
        prod_mag = mul_p[2*MUL_W-1] ? DS_W'(-mul_p) : DS_W'(mul_p);
    end

    always_comb begin
        mul_start = 1'b0;
        ds_start  = 1'b0;
        mul_a     = '0;
        mul_b     = '0;
        ds_mode   = DS_DIV;
        ds_num    = acc_reg[DS_W-1:0];
        if (state_reg == ST_ISSUE) begin
            case (step_reg)
                5'd0, 5'd4: begin
                    mul_start = 1'b1;
                    mul_a = MUL_W'(gpxz_reg);
                    mul_b = MUL_W'(ep_sel);
                end
                5'd2: begin
                    mul_start = 1'b1;
                    mul_a = MUL_W'(gpy_reg);
                    mul_b = MUL_W'(ep_sel);
                end
                5'd1, K_CY, 5'd5: begin
                    mul_start = 1'b1;
                    mul_a = MUL_W'(gvel_reg);
                    mul_b = MUL_W'(ev_sel);
                end
                5'd6, K_CZ2: begin
                    mul_start = 1'b1;
                    mul_a = MUL_W'(c_reg[ax]);
                    mul_b = MUL_W'(c_reg[ax]);
                end
                K_LIM: begin
                    mul_start = 1'b1;
                    mul_a = MUL_W'(maxxz_reg);
                    mul_b = MUL_W'(maxxz_reg);
                end
                K_SQRT: begin
                    ds_start = 1'b1;
                    ds_mode  = DS_SQRT;
                    ds_num   = n2_reg;
                end
                5'd10, 5'd12: begin
                    mul_start = 1'b1;
                    mul_a = MUL_W'(c_reg[ax]);
                    mul_b = MUL_W'(maxxz_reg);
                end
                K_DIVX, K_DIVZ: begin
                    ds_start = 1'b1;
                    ds_mode  = DS_DIV;
                    ds_num   = acc_reg[DS_W-1:0];
                end
                default: begin
                    mul_start = 1'b1;
                    mul_a = (step_reg == 5'd15) ? MUL_W'(lagy_reg) : MUL_W'(lagxz_reg);
                    mul_b = MUL_W'(c_reg[ax]) - MUL_W'(vel_reg[ax]);
                end
            endcase
        end
    end

    always_comb begin
        if (step_reg == K_LIM && !(n2_reg > mul_p[DS_W-1:0])) begin
            step_next = K_LAGX;
        end else begin
            step_next = step_reg + 1'b1;
        end
    end

    vpd_mul u_mul (
        .aclk(aclk), .aresetn(aresetn), .start(mul_start),
        .a(mul_a), .b(mul_b), .done(mul_done), .p(mul_p)
    );

    vpd_divsqrt u_ds (
        .aclk(aclk), .aresetn(aresetn), .start(ds_start), .mode(ds_mode),
        .num(ds_num), .den(n_reg), .done(ds_done), .result(ds_res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            step_reg    <= '0;
            m_valid_reg <= 1'b0;
            gpxz_reg <= '0; gvel_reg <= '0; gpy_reg <= '0; maxxz_reg <= '0;
            maxy_reg <= '0; miny_reg <= '0; lagxz_reg <= '0; lagy_reg <= '0;
            for (int i = 0; i < 3; i++) begin
                pos_reg[i] <= '0;
                vel_reg[i] <= '0;
            end
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    R_GPXZ:  gpxz_reg  <= cfg_data;
                    R_GVEL:  gvel_reg  <= cfg_data;
                    R_GPY:   gpy_reg   <= cfg_data;
                    R_MAXXZ: maxxz_reg <= cfg_data[30:0];
                    R_MAXY:  maxy_reg  <= cfg_data;
                    R_MINY:  miny_reg  <= cfg_data;
                    R_LAGXZ: lagxz_reg <= cfg_data[15:0];
                    R_LAGY:  lagy_reg  <= cfg_data[15:0];
                    default: ;
                endcase
            end
            if (m_valid_reg && m_tready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_acc) begin
                        step_reg  <= '0;
                        state_reg <= s_tuser[0] ? ST_FIN : ST_ISSUE;
                    end
                end
                ST_ISSUE: state_reg <= ST_WAIT;
                ST_WAIT: begin
                    if (mul_done || ds_done) begin
                        step_reg  <= step_next;
                        state_reg <= (step_reg == K_LAGZ) ? ST_FIN : ST_ISSUE;
                    end
                end
                ST_FIN: begin
                    if (out_free) begin
                        m_valid_reg <= 1'b1;
                        state_reg   <= ST_IDLE;
                        for (int i = 0; i < 3; i++) begin
                            if (op_reg) begin
                                pos_reg[i] <= aimp_reg[i];
                                vel_reg[i] <= aimv_reg[i];
                            end else begin
                                pos_reg[i] <= sat32(70'(pos_reg[i]) +
                                                    (70'(vel_reg[i]) >>> STEP_SHIFT));
                                vel_reg[i] <= nv_reg[i];
                            end
                        end
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // datapath captures
    always_ff @(posedge aclk) begin
        if (s_acc) begin
            op_reg <= s_tuser[0];
            hl_reg <= 1'b0;
            vl_reg <= 1'b0;
            for (int i = 0; i < 3; i++) begin
                aimp_reg[i] <= s_tdata[32*i +: 32];
                aimv_reg[i] <= s_tdata[96 + 32*i +: 32];
            end
        end
        if (state_reg == ST_WAIT && (mul_done || ds_done)) begin
            case (step_reg)
                5'd0, 5'd2, 5'd4, 5'd6: acc_reg <= mul_p;
                5'd1, 5'd5: c_reg[ax] <= cmd;
                K_CY: begin
                    if (cmd > maxy_reg) begin
                        c_reg[1] <= maxy_reg;
                        vl_reg   <= 1'b1;
                    end else if (cmd < miny_reg) begin
                        c_reg[1] <= miny_reg;
                        vl_reg   <= 1'b1;
                    end else begin
                        c_reg[1] <= cmd;
                    end
                end
                K_CZ2: n2_reg <= acc_reg[DS_W-1:0] + mul_p[DS_W-1:0];
                K_LIM: hl_reg <= n2_reg > mul_p[DS_W-1:0];
                K_SQRT: n_reg <= DEN_W'(ds_res[31:0]);
                5'd10, 5'd12: begin
                    acc_reg <= (2*MUL_W)'(prod_mag);
                    neg_reg <= mul_p[2*MUL_W-1];
                end
                K_DIVX, K_DIVZ: c_reg[ax] <= neg_reg ? 32'(32'd0 - ds_res[31:0])
                                                     : ds_res[31:0];
                default: nv_reg[ax] <= sat32(70'(vel_reg[ax]) + (70'(mul_p) >>> 16));
            endcase
        end
        if (state_reg == ST_FIN && out_free) begin
            for (int i = 0; i < 3; i++) begin
                if (op_reg) begin
                    m_data_reg[32*i +: 32]      <= aimp_reg[i];
                    m_data_reg[96 + 32*i +: 32] <= aimv_reg[i];
                end else begin
                    m_data_reg[32*i +: 32]      <= sat32(70'(pos_reg[i]) +
                                                         (70'(vel_reg[i]) >>> STEP_SHIFT));
                    m_data_reg[96 + 32*i +: 32] <= nv_reg[i];
                end
            end
            m_data_reg[192] <= op_reg ? 1'b0 : hl_reg;
            m_data_reg[193] <= op_reg ? 1'b0 : vl_reg;
            m_data_reg[199:194] <= '0;
        end
    end

`ifndef SYNTHESIS
    a_mul_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        mul_done |-> state_reg == ST_WAIT)
        else $error("multiplier finished outside wait");
    a_ds_step: assert property (@(posedge aclk) disable iff (!aresetn)
        ds_done |-> state_reg == ST_WAIT &&
                    (step_reg == K_SQRT || step_reg == K_DIVX || step_reg == K_DIVZ))
        else $error("divsqrt finished at wrong step");
    a_one_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second beat taken while busy");
    a_fin_out: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_FIN && out_free |=> m_tvalid)
        else $error("result not presented");
`endif
endmodule

### hdl/vpd_mul.sv
// Bit-serial signed multiplier, one multiplier bit per cycle.
// Depends on vpd_pkg.
module vpd_mul (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               start,
    input  logic signed [vpd_pkg::MUL_W-1:0]   a,
    input  logic signed [vpd_pkg::MUL_W-1:0]   b,
    output logic                               done,
    output logic signed [2*vpd_pkg::MUL_W-1:0] p
);
    import vpd_pkg::*;

    localparam int CW = $clog2(MUL_W);

    logic signed [MUL_W-1:0] a_reg;
    logic [MUL_W-1:0]        b_reg;
    logic signed [MUL_W:0]   hi_reg;
    logic [MUL_W-1:0]        lo_reg;
    logic [CW-1:0]           cnt_reg;
    logic                    busy_reg, done_reg;
    logic                    last;
    logic signed [MUL_W:0]   addend, sum;

    assign last = cnt_reg == CW'(MUL_W - 1);

    always_comb begin
        if (!b_reg[0]) begin
            addend = '0;
        end else if (last) begin
            addend = -(MUL_W+1)'(a_reg);
        end else begin
            addend = (MUL_W+1)'(a_reg);
        end
        sum = hi_reg + addend;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start && !busy_reg) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (last) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start && !busy_reg) begin
            a_reg  <= a;
            b_reg  <= b;
            hi_reg <= '0;
            lo_reg <= '0;
        end else if (busy_reg) begin
            hi_reg <= sum >>> 1;
            lo_reg <= {sum[0], lo_reg[MUL_W-1:1]};
            b_reg  <= b_reg >> 1;
        end
    end

    assign done = done_reg;
    assign p = {hi_reg[MUL_W-1:0], lo_reg};

`ifndef SYNTHESIS
    a_done_end: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg && last |=> done && !busy_reg)
        else $error("multiplier done missing");
    a_busy_cnt: assert property (@(posedge aclk) disable iff (!aresetn)
        !busy_reg |=> !done || $past(last))
        else $error("spurious multiplier done");
    a_count: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg && !last |=> busy_reg && cnt_reg == $past(cnt_reg) + 1'b1)
        else $error("multiplier count slip");
`endif
endmodule

### hdl/vpd_divsqrt.sv
// Bit-serial unsigned divider (one quotient bit per cycle) and integer
// square root (one root bit per cycle) sharing one remainder path. Depends on vpd_pkg.
module vpd_divsqrt (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  vpd_pkg::ds_mode_t             mode,
    input  logic [vpd_pkg::DS_W-1:0]      num,
    input  logic [vpd_pkg::DEN_W-1:0]     den,
    output logic                          done,
    output logic [vpd_pkg::DS_W-1:0]      result
);
    import vpd_pkg::*;

    localparam int CW = $clog2(DS_W) + 1;

    ds_mode_t            mode_reg;
    logic [DS_W-1:0]     x_reg, q_reg;
    logic [DS_REM_W-1:0] rem_reg;
    logic [DEN_W-1:0]    den_reg;
    logic [CW-1:0]       cnt_reg;
    logic                busy_reg, done_reg;
    logic                last;
    logic [DS_REM_W-1:0] remsh, trial, diff;
    logic                fits;

    always_comb begin
        case (mode_reg)
            DS_SQRT: begin
                last  = cnt_reg == CW'(DS_W/2 - 1);
                remsh = {rem_reg[DS_REM_W-3:0], x_reg[DS_W-1:DS_W-2]};
                trial = {q_reg[DS_REM_W-3:0], 2'b01};
            end
            default: begin
                last  = cnt_reg == CW'(DS_W - 1);
                remsh = {rem_reg[DS_REM_W-2:0], x_reg[DS_W-1]};
                trial = DS_REM_W'(den_reg);
            end
        endcase
        fits = remsh >= trial;
        diff = remsh - trial;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start && !busy_reg) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (last) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start && !busy_reg) begin
            mode_reg <= mode;
            x_reg    <= num;
            den_reg  <= den;
            q_reg    <= '0;
            rem_reg  <= '0;
        end else if (busy_reg) begin
            rem_reg <= fits ? diff : remsh;
            q_reg   <= {q_reg[DS_W-2:0], fits};
            x_reg   <= (mode_reg == DS_SQRT) ? {x_reg[DS_W-3:0], 2'b00}
                                             : {x_reg[DS_W-2:0], 1'b0};
        end
    end

    assign done = done_reg;
    assign result = q_reg;

`ifndef SYNTHESIS
    a_done: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg && last |=> done)
        else $error("divsqrt done missing");
    a_hold_mode: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg && !last |=> $stable(mode_reg) && $stable(den_reg))
        else $error("divsqrt operands changed mid-run");
    a_no_done_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        !busy_reg |=> !done)
        else $error("divsqrt done without run");
`endif
endmodule

### tb/sv/vehicle_pd_velocity_step_unit_tb.sv
// Testbench for vehicle_pd_velocity_step_unit: drives step and load beats with random
// idling, predicts each result with a local PD/Euler model and compares field by field.
// Depends on vpd_pkg and the RTL in hdl/.
`timescale 1ns / 1ps

module vehicle_pd_velocity_step_unit_tb;

    localparam int STEP_SH = vpd_pkg::STEP_SHIFT_DEF;
    localparam logic OP_STEP = 1'b0;
    localparam logic OP_LOAD = 1'b1;
    localparam logic [2:0] REG_GAIN_POS_XZ = 3'd0;
    localparam logic [2:0] REG_GAIN_VEL = 3'd1;
    localparam logic [2:0] REG_GAIN_POS_Y = 3'd2;
    localparam logic [2:0] REG_MAX_SPEED_XZ = 3'd3;
    localparam logic [2:0] REG_MAX_SPEED_Y = 3'd4;
    localparam logic [2:0] REG_MIN_SPEED_Y = 3'd5;
    localparam logic [2:0] REG_LAG_XZ = 3'd6;
    localparam logic [2:0] REG_LAG_Y = 3'd7;
    localparam longint CYCLE_LIMIT = 3000000;

    typedef struct packed {
        logic       vert_limited;
        logic       horiz_limited;
        logic [31:0] vel_z, vel_y, vel_x, pos_z, pos_y, pos_x;
    } motion_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [191:0] s_tdata = '0;
    logic [0:0]   s_tuser = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [199:0] m_tdata;
    logic         cfg_valid = 1'b0;
    logic         cfg_ready;
    logic [2:0]   cfg_index = '0;
    logic [31:0]  cfg_data = '0;

    vehicle_pd_velocity_step_unit u_top (.*);

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // predictor state
    longint g_pxz, g_vel, g_py, lim_xz, top_y, bot_y, lag_xz, lag_y;
    longint pos_st[3], vel_st[3];
    motion_t motion_q[$];
    int errors = 0;
    bit src_idle_en = 1'b1, snk_idle_en = 1'b1;
    int hold_off = 0;
    longint cycles = 0;

    function automatic longint sat(input longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint fshift(input longint v, input int s);
        return v >>> s;
    endfunction

    function automatic longint root64(input longint unsigned n);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n) b >>= 2;
        while (b != 0) begin
            if (n >= r + b) begin
                n -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return longint'(r);
    endfunction

    function automatic longint pd_cmd(input longint gp, input int a, input longint ap,
                                      input longint av);
        longint ep, ev;
        ep = sat(pos_st[a] - ap);
        ev = sat(vel_st[a] - av);
        return sat(fshift(gp * ep + g_vel * ev, 16));
    endfunction

    function automatic motion_t predict_motion(input logic op, input logic [191:0] d);
        longint ap[3], av[3], c[3], np[3], nv[3], n, lg;
        longint unsigned n2, l2;
        motion_t r;
        r = '0;
        for (int i = 0; i < 3; i++) begin
            ap[i] = longint'($signed(d[32*i +: 32]));
            av[i] = longint'($signed(d[96 + 32*i +: 32]));
        end
        if (op == OP_LOAD) begin
            np = ap;
            nv = av;
        end else begin
            c[0] = pd_cmd(g_pxz, 0, ap[0], av[0]);
            c[1] = pd_cmd(g_py, 1, ap[1], av[1]);
            c[2] = pd_cmd(g_pxz, 2, ap[2], av[2]);
            n2 = longint'(c[0] * c[0]) + longint'(c[2] * c[2]);
            l2 = lim_xz * lim_xz;
            if (n2 > l2) begin
                n = root64(n2);
                c[0] = (c[0] * lim_xz) / n;
                c[2] = (c[2] * lim_xz) / n;
                r.horiz_limited = 1'b1;
            end
            if (c[1] > top_y) begin
                c[1] = top_y;
                r.vert_limited = 1'b1;
            end else if (c[1] < bot_y) begin
                c[1] = bot_y;
                r.vert_limited = 1'b1;
            end
            for (int i = 0; i < 3; i++) begin
                lg = (i == 1) ? lag_y : lag_xz;
                np[i] = sat(pos_st[i] + fshift(vel_st[i], STEP_SH));
                nv[i] = sat(vel_st[i] + fshift(lg * (c[i] - vel_st[i]), 16));
            end
        end
        pos_st = np;
        vel_st = nv;
        r.pos_x = np[0][31:0]; r.pos_y = np[1][31:0]; r.pos_z = np[2][31:0];
        r.vel_x = nv[0][31:0]; r.vel_y = nv[1][31:0]; r.vel_z = nv[2][31:0];
        return r;
    endfunction

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("%0t timeout", $time);
            $display("== FAIL ==");
            $finish;
        end
    end

    // sink: random stalls, long hold-off on request
    always @(posedge aclk) begin
        motion_t got, exp_m;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata[193:0];
            if (motion_q.size() == 0) begin
                $display("%0t unexpected beat %h", $time, got);
                errors++;
            end else begin
                exp_m = motion_q.pop_front();
                if (got.pos_x !== exp_m.pos_x) begin
                    $display("%0t pos_x exp %h got %h", $time, exp_m.pos_x, got.pos_x);
                    errors++;
                end
                if (got.pos_y !== exp_m.pos_y) begin
                    $display("%0t pos_y exp %h got %h", $time, exp_m.pos_y, got.pos_y);
                    errors++;
                end
                if (got.pos_z !== exp_m.pos_z) begin
                    $display("%0t pos_z exp %h got %h", $time, exp_m.pos_z, got.pos_z);
                    errors++;
                end
                if (got.vel_x !== exp_m.vel_x) begin
                    $display("%0t vel_x exp %h got %h", $time, exp_m.vel_x, got.vel_x);
                    errors++;
                end
                if (got.vel_y !== exp_m.vel_y) begin
                    $display("%0t vel_y exp %h got %h", $time, exp_m.vel_y, got.vel_y);
                    errors++;
                end
                if (got.vel_z !== exp_m.vel_z) begin
                    $display("%0t vel_z exp %h got %h", $time, exp_m.vel_z, got.vel_z);
                    errors++;
                end
                if (got.horiz_limited !== exp_m.horiz_limited) begin
                    $display("%0t horiz_limited exp %b got %b", $time,
                             exp_m.horiz_limited, got.horiz_limited);
                    errors++;
                end
                if (got.vert_limited !== exp_m.vert_limited) begin
                    $display("%0t vert_limited exp %b got %b", $time,
                             exp_m.vert_limited, got.vert_limited);
                    errors++;
                end
            end
        end
    end

    int snk_gap = 0;
    always @(posedge aclk) begin
        if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            m_tready <= 1'b0;
        end else if (snk_gap > 0) begin
            snk_gap <= snk_gap - 1;
            m_tready <= 1'b0;
        end else if (snk_idle_en && $urandom_range(0, 5) == 0) begin
            snk_gap <= $urandom_range(1, 11) - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    task automatic send_beat(input logic op, input logic [191:0] d);
        int gap;
        if (src_idle_en && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 11);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= d;
        s_tuser <= op;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        motion_q.push_back(predict_motion(op, d));
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (motion_q.size() != 0) @(posedge aclk);
        repeat (600) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] v);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= v;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        case (idx)
            REG_GAIN_POS_XZ:  g_pxz = longint'($signed(v));
            REG_GAIN_VEL:     g_vel = longint'($signed(v));
            REG_GAIN_POS_Y:   g_py = longint'($signed(v));
            REG_MAX_SPEED_XZ: lim_xz = longint'(v[30:0]);
            REG_MAX_SPEED_Y:  top_y = longint'($signed(v));
            REG_MIN_SPEED_Y:  bot_y = longint'($signed(v));
            REG_LAG_XZ:       lag_xz = longint'(v[15:0]);
            default:          lag_y = longint'(v[15:0]);
        endcase
    endtask

    task automatic set_all(input logic [31:0] gp, gv, gy, mx, my, ny, lx, ly);
        write_reg(REG_GAIN_POS_XZ, gp);
        write_reg(REG_GAIN_VEL, gv);
        write_reg(REG_GAIN_POS_Y, gy);
        write_reg(REG_MAX_SPEED_XZ, mx);
        write_reg(REG_MAX_SPEED_Y, my);
        write_reg(REG_MIN_SPEED_Y, ny);
        write_reg(REG_LAG_XZ, lx);
        write_reg(REG_LAG_Y, ly);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [31:0] rnd_word();
        case ($urandom_range(0, 5))
            0: return 32'h7fffffff;
            1: return 32'h80000000;
            2: return $urandom_range(0, 32'h0003ffff) - 32'h00020000;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [191:0] rnd_aim();
        logic [191:0] d;
        for (int i = 0; i < 6; i++) d[32*i +: 32] = rnd_word();
        return d;
    endfunction

    function automatic logic [191:0] near_aim(input int spread);
        logic [191:0] d;
        for (int i = 0; i < 3; i++) begin
            d[32*i +: 32] = 32'(pos_st[i] + $signed($urandom_range(0, 2*spread)) - spread);
            d[96 + 32*i +: 32] = 32'(vel_st[i] + $signed($urandom_range(0, 2*spread))
                                     - spread);
        end
        return d;
    endfunction

    task automatic test_directed();
        set_all(32'h0001_0000, 32'h0000_8000, 32'h0002_0000, 32'h0001_0000,
                32'h0000_8000, 32'hffff_8000, 32'h0000_4000, 32'h0000_8000);
        send_beat(OP_STEP, '0);
        send_beat(OP_LOAD, {6{32'h7fffffff}});
        send_beat(OP_STEP, '0);
        send_beat(OP_LOAD, {6{32'h80000000}});
        send_beat(OP_STEP, {6{32'h7fffffff}});
        send_beat(OP_STEP, {6{32'h80000000}});
        send_beat(OP_LOAD, '0);
        send_beat(OP_STEP, {32'h0, 32'h0, 32'h0, 32'h0003_0000, 32'h0, 32'h0004_0000});
        send_beat(OP_STEP, {32'h0, 32'h0, 32'h0, 32'h0, 32'hfff0_0000, 32'h0});
        wait_drained();
        // crossed vertical limits, zero horizontal limit, extreme gains and lags
        set_all(32'h7fffffff, 32'h80000000, 32'h80000000, 32'h0,
                32'hffff_0000, 32'h0001_0000, 32'h0000ffff, 32'h0000ffff);
        send_beat(OP_STEP, {32'h0, 32'h0, 32'h0, 32'h0002_0000, 32'h0, 32'hfffe_0000});
        send_beat(OP_STEP, {32'h0, 32'h0, 32'h0, 32'h0, 32'h0000_8000, 32'h0});
        send_beat(OP_STEP, '0);
        send_beat(OP_STEP, {6{32'h12345678}});
        send_beat(OP_LOAD, {32'h1, 32'h2, 32'h3, 32'h4, 32'h5, 32'h6});
        send_beat(OP_STEP, {6{32'hedcba987}});
        wait_drained();
        set_all(32'h80000000, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                32'h7fffffff, 32'h80000000, 32'h0, 32'h0);
        send_beat(OP_STEP, {6{32'h80000000}});
        send_beat(OP_STEP, {6{32'h7fffffff}});
        send_beat(OP_STEP, {6{32'h55555555}});
        wait_drained();
    endtask

    task automatic test_backpressure();
        hold_off = 3000;
        for (int i = 0; i < 6; i++) send_beat(OP_STEP, rnd_aim());
        wait_drained();
    endtask

    task automatic test_random(input int n);
        logic [31:0] r;
        for (int p = 0; p < 4; p++) begin
            set_all(rnd_word(), rnd_word(), rnd_word(), $urandom,
                    rnd_word(), rnd_word(), $urandom, $urandom);
            if (p == 3) begin
                src_idle_en = 1'b0;
                snk_idle_en = 1'b0;
            end
            for (int i = 0; i < n / 4; i++) begin
                r = $urandom_range(0, 9);
                if (r == 0) send_beat(OP_LOAD, rnd_aim());
                else if (r < 3) send_beat(OP_STEP, rnd_aim());
                else send_beat(OP_STEP, near_aim($urandom_range(1, 32'h00100000)));
            end
            wait_drained();
        end
    endtask

    initial begin
        g_pxz = 0; g_vel = 0; g_py = 0; lim_xz = 0;
        top_y = 0; bot_y = 0; lag_xz = 0; lag_y = 0;
        for (int i = 0; i < 3; i++) begin
            pos_st[i] = 0;
            vel_st[i] = 0;
        end
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_backpressure();
        test_random(380);
        if (errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
